FILE: src/matrix_multiply_assert.svh
// Assertion macros shared by the matrix multiply RTL.
// Both expect a signal named clk in the module that uses them; MM_ASSERT also expects rst.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every edge outside reset.
`define MM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define MM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MM_ASSERT(label, prop, msg)
`define MM_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: src/mm_pkg.sv
`default_nettype none

package mm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_W  = 4;   // dimension register width
  localparam int IDX_W  = 3;   // row / column field width
  localparam int VAL_W  = 32;  // entry width
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;  // config port data width
  localparam int ADDR_W = 4;   // config port address width

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;  // zero or oversized dimension
  localparam logic [STAT_W-1:0] ST_CALC = 2'd2;  // inner dimensions differ

  // register indexes
  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_COLS_A = 2'd1;
  localparam logic [1:0] REG_ROWS_B = 2'd2;
  localparam logic [1:0] REG_COLS_B = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_READ,
    S_MULT,
    S_ACC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic mult_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: src/mm_ram.sv
`default_nettype none

module mm_ram #(
  parameter int WIDTH = mm_pkg::VAL_W,
  parameter int DEPTH = mm_pkg::MAX_DIM_DEF * mm_pkg::MAX_DIM_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/mm_mac.sv
`default_nettype none

module mm_mac #(
  parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire mm_pkg::mac_ctrl_t               ctrl,
  input  wire logic        [mm_pkg::VAL_W-1:0] a_data,
  input  wire logic        [mm_pkg::VAL_W-1:0] b_data,
  output logic signed      [mm_pkg::VAL_W-1:0] sum
);

  localparam int VW    = mm_pkg::VAL_W;
  localparam int PW    = 2 * VW;
  // exact sum of up to MAX_DIM full products
  localparam int ACC_W = PW + $clog2(MAX_DIM);

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;

  always_ff @(posedge clk) begin
    if (ctrl.mult_en) begin
      prod <= $signed(a_data) * $signed(b_data);
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // drop the fraction bits, rounding toward minus infinity, then saturate
  always_comb begin
    shifted = acc >>> FRAC_BITS;
    if (shifted > SAT_HI) begin
      sum = SAT_HI[VW-1:0];
    end else if (shifted < SAT_LO) begin
      sum = SAT_LO[VW-1:0];
    end else begin
      sum = shifted[VW-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/matrix_multiply.sv
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+----------------------------------------------
// request   | start / busy                  | req_type, row_index, col_index, entry_value
// result    | result_valid (one cycle)      | product_value, out_row, out_col, status, last
// registers | APB psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// Entry writes never raise busy, so they can arrive back to back.
// A compute run holds busy while each product term goes through a RAM read, the shared
// 32x32 multiplier and the accumulator in turn, and each entry of C adds an output state.
// A dimension error raises busy only while the sequencer is in S_ERR.
// rst is synchronous; it sets the dimension registers to 1 and leaves the entry RAMs as is.
// Results cannot be stalled: each one is shown for a single cycle with result_valid high.
`default_nettype none

`include "matrix_multiply_assert.svh"

module matrix_multiply #(
  parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // request
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic        [mm_pkg::REQ_W-1:0] req_type,
  input  wire logic        [mm_pkg::IDX_W-1:0] row_index,
  input  wire logic        [mm_pkg::IDX_W-1:0] col_index,
  input  wire logic signed [mm_pkg::VAL_W-1:0] entry_value,
  // result
  output logic                              result_valid,
  output logic signed      [mm_pkg::VAL_W-1:0] product_value,
  output logic             [mm_pkg::IDX_W-1:0] out_row,
  output logic             [mm_pkg::IDX_W-1:0] out_col,
  output logic             [mm_pkg::STAT_W-1:0] status,
  output logic                              last,
  // registers
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic        [mm_pkg::ADDR_W-1:0] paddr,
  input  wire logic        [mm_pkg::DATA_W-1:0] pwdata,
  output logic             [mm_pkg::DATA_W-1:0] prdata,
  output logic                              pready
);

  localparam int CW    = mm_pkg::CFG_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  logic [CW-1:0] rows_a, cols_a, rows_b, cols_b;

  mm_pkg::state_t state, state_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] k, k_next;
  logic [mm_pkg::STAT_W-1:0] err_code, err_code_next;

  logic accept;
  logic cfg_write;
  logic in_range;
  logic dims_bad;
  logic last_k;
  logic last_j;
  logic last_i;

  logic          a_we, b_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] a_raddr, b_raddr;
  logic [mm_pkg::VAL_W-1:0] a_rdata, b_rdata;
  logic signed [mm_pkg::VAL_W-1:0] sum;
  mm_pkg::mac_ctrl_t mac_ctrl;

  // ---------------- register port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= CW'(1);
      cols_a <= CW'(1);
      rows_b <= CW'(1);
      cols_b <= CW'(1);
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        mm_pkg::REG_ROWS_A: rows_a <= pwdata[CW-1:0];
        mm_pkg::REG_COLS_A: cols_a <= pwdata[CW-1:0];
        mm_pkg::REG_ROWS_B: rows_b <= pwdata[CW-1:0];
        mm_pkg::REG_COLS_B: cols_b <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mm_pkg::REG_ROWS_A: prdata = mm_pkg::DATA_W'(rows_a);
      mm_pkg::REG_COLS_A: prdata = mm_pkg::DATA_W'(cols_a);
      mm_pkg::REG_ROWS_B: prdata = mm_pkg::DATA_W'(rows_b);
      mm_pkg::REG_COLS_B: prdata = mm_pkg::DATA_W'(cols_b);
      default:            prdata = '0;
    endcase
  end

  // ---------------- checks and addresses ----------------
  assign accept   = start && !busy;
  assign in_range = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
  assign dims_bad = (rows_a == '0) || (int'(rows_a) > MAX_DIM) ||
                    (cols_a == '0) || (int'(cols_a) > MAX_DIM) ||
                    (rows_b == '0) || (int'(rows_b) > MAX_DIM) ||
                    (cols_b == '0) || (int'(cols_b) > MAX_DIM);

  assign last_k = (k == cols_a - CW'(1));
  assign last_j = (j == cols_b - CW'(1));
  assign last_i = (i == rows_a - CW'(1));

  assign waddr   = AW'(row_index) * AW'(MAX_DIM) + AW'(col_index);
  assign a_raddr = AW'(i) * AW'(MAX_DIM) + AW'(k);
  assign b_raddr = AW'(k) * AW'(MAX_DIM) + AW'(j);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mm_pkg::S_IDLE;
      i        <= '0;
      j        <= '0;
      k        <= '0;
      err_code <= mm_pkg::ST_OK;
    end else begin
      state    <= state_next;
      i        <= i_next;
      j        <= j_next;
      k        <= k_next;
      err_code <= err_code_next;
    end
  end

  always_comb begin
    state_next    = state;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    err_code_next = err_code;
    unique case (state)
      mm_pkg::S_IDLE: begin
        if (accept && req_type == mm_pkg::REQ_COMPUTE) begin
          i_next = '0;
          j_next = '0;
          k_next = '0;
          if (cols_a != rows_b) begin
            err_code_next = mm_pkg::ST_CALC;
            state_next    = mm_pkg::S_ERR;
          end else if (dims_bad) begin
            err_code_next = mm_pkg::ST_BAD;
            state_next    = mm_pkg::S_ERR;
          end else begin
            err_code_next = mm_pkg::ST_OK;
            state_next    = mm_pkg::S_READ;
          end
        end
      end
      mm_pkg::S_ERR:  state_next = mm_pkg::S_IDLE;
      mm_pkg::S_READ: state_next = mm_pkg::S_MULT;
      mm_pkg::S_MULT: state_next = mm_pkg::S_ACC;
      mm_pkg::S_ACC: begin
        if (last_k) begin
          state_next = mm_pkg::S_OUT;
        end else begin
          k_next     = k + CW'(1);
          state_next = mm_pkg::S_READ;
        end
      end
      mm_pkg::S_OUT: begin
        k_next = '0;
        if (last_j) begin
          j_next = '0;
          if (last_i) begin
            state_next = mm_pkg::S_IDLE;
          end else begin
            i_next     = i + CW'(1);
            state_next = mm_pkg::S_READ;
          end
        end else begin
          j_next     = j + CW'(1);
          state_next = mm_pkg::S_READ;
        end
      end
      default: state_next = mm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state != mm_pkg::S_IDLE);
    a_we          = accept && in_range && (req_type == mm_pkg::REQ_WRITE_A);
    b_we          = accept && in_range && (req_type == mm_pkg::REQ_WRITE_B);
    mac_ctrl      = '0;
    result_valid  = 1'b0;
    product_value = '0;
    out_row       = '0;
    out_col       = '0;
    status        = mm_pkg::ST_OK;
    last          = 1'b0;
    unique case (state)
      mm_pkg::S_IDLE: mac_ctrl.clear = 1'b1;
      mm_pkg::S_ERR: begin
        result_valid = 1'b1;
        status       = err_code;
        last         = 1'b1;
      end
      mm_pkg::S_READ: ;
      mm_pkg::S_MULT: mac_ctrl.mult_en = 1'b1;
      mm_pkg::S_ACC:  mac_ctrl.acc_en  = 1'b1;
      mm_pkg::S_OUT: begin
        mac_ctrl.clear = 1'b1;
        result_valid   = 1'b1;
        product_value  = sum;
        out_row        = i[mm_pkg::IDX_W-1:0];
        out_col        = j[mm_pkg::IDX_W-1:0];
        last           = last_i && last_j;
      end
      default: ;
    endcase
  end

  // ---------------- storage and datapath ----------------
  mm_ram #(
    .WIDTH (mm_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (entry_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mm_ram #(
    .WIDTH (mm_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (entry_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mm_mac #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .a_data (a_rdata),
    .b_data (b_rdata),
    .sum    (sum)
  );

  // ---------------- checks ----------------
  `MM_ASSERT(a_result_while_busy, result_valid |-> busy, "result outside a run")
  `MM_ASSERT(a_idle_after_last, (result_valid && last) |=> !busy, "busy after last result")
  `MM_ASSERT(a_error_is_last, (result_valid && status != mm_pkg::ST_OK) |-> last, "error not last")
  `MM_ASSERT(a_compute_busy, (accept && req_type == mm_pkg::REQ_COMPUTE) |=> busy, "not busy")
  `MM_ASSERT_ALWAYS(a_no_ram_write_busy, busy |-> !(a_we || b_we), "write while busy")

endmodule

`default_nettype wire
